### sv/cwf_pkg.sv
`timescale 1ns / 1ps
package cwf_pkg;

  localparam int TAPS      = 4;
  localparam int TAPS_LOG2 = $clog2(TAPS);
  localparam int SMP_W     = 16;
  localparam int PROD_W    = 2 * SMP_W;
  localparam int ACC_W     = PROD_W + TAPS_LOG2;
  localparam int FRAC_W    = 14;
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;

  typedef logic signed [SMP_W-1:0]  smp_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  typedef enum logic [2:0] {
    REG_MODE      = 3'd0,
    REG_THRESHOLD = 3'd1,
    REG_W_OLDEST  = 3'd2,
    REG_W_SECOND  = 3'd3,
    REG_W_THIRD   = 3'd4,
    REG_W_NEWEST  = 3'd5
  } reg_idx_t;

  localparam logic              MODE_RESET   = 1'b0;
  localparam logic [SMP_W-1:0]  THRESH_RESET = 16'hffff;
  localparam smp_t              WEIGHT_RESET = 16'sd4096;

  typedef struct packed {
    logic              weighted;
    logic [SMP_W-1:0]  threshold;
    smp_t              w_oldest;
    smp_t              w_second;
    smp_t              w_third;
    smp_t              w_newest;
  } cfg_t;

  typedef struct packed {
    logic shift;
    logic prime;
    logic advance;
    logic weighted;
  } cell_ctrl_t;

  function automatic smp_t weight_for(cfg_t cfg, int idx);
    smp_t w;
    if (idx == TAPS - 1) begin
      w = cfg.w_newest;
    end else if (idx == 0) begin
      w = cfg.w_oldest;
    end else if (idx == 1) begin
      w = cfg.w_second;
    end else begin
      w = cfg.w_third;
    end
    return w;
  endfunction

endpackage

### sv/cwf_stream_if.sv
`timescale 1ns / 1ps
interface cwf_in_if;
  logic               valid;
  logic               ready;
  cwf_pkg::smp_t      sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface cwf_out_if;
  logic               valid;
  logic               ready;
  cwf_pkg::smp_t      filtered_out;
  logic               was_clipped;

  modport source (output valid, output filtered_out, output was_clipped, input ready);
  modport sink   (input valid, input filtered_out, input was_clipped, output ready);
endinterface

### sv/clipped_and_weighted_window_filter.sv
`timescale 1ns / 1ps
// Clipped moving average / weighted window filter.
// Input channel in_chan: one signed 16-bit sample per request (valid/ready).
// Output channel out_chan: filtered_out and was_clipped, one request per sample.
// Configuration: APB write/read of mode, clip threshold and four Q2.14 weights;
// write only while no sample is in flight.
// Flow: an accepted sample passes the window, product and output registers to out_chan.
// Throughput: one sample per cycle while out_chan takes its requests; the window
// shift register, the per-cell multiplier stage and the summing/saturation output
// register advance together.
// Stall: while out_chan holds a request that is not taken, the whole pipeline
// holds and in_chan.ready drops; nothing is lost or repeated.
// Reset: rst_n clears the valid flags, the primed flag and the registers to
// mode 0, threshold 65535 and weights 4096; the first sample afterwards fills
// every cell of the window.
module clipped_and_weighted_window_filter (
  input  logic                          clk,
  input  logic                          rst_n,
  cwf_in_if.sink                        in_chan,
  cwf_out_if.source                     out_chan,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cwf_pkg::ADDR_W-1:0]    paddr,
  input  logic [cwf_pkg::DATA_W-1:0]    pwdata,
  output logic [cwf_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);
  import cwf_pkg::*;

  cfg_t               cfg;
  cell_ctrl_t         ctrl;
  smp_t [TAPS-1:0]    win;
  prod_t [TAPS-1:0]   prods;
  logic               advance;
  logic               accept;
  logic               primed_r;
  logic               v1_r;
  logic               v2_r;
  logic               clip1_r;
  logic               clip2_r;
  smp_t               ref_smp;
  smp_t               accepted;
  logic signed [SMP_W:0] diff;
  logic [SMP_W:0]     mag;
  logic               clip;

  cwf_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign in_chan.ready = advance;
  assign accept        = in_chan.valid && advance;

  assign ref_smp  = primed_r ? win[TAPS-1] : in_chan.sample_in;
  assign diff     = (SMP_W+1)'(in_chan.sample_in) - (SMP_W+1)'(ref_smp);
  assign mag      = diff[SMP_W] ? (SMP_W+1)'(-diff) : (SMP_W+1)'(diff);
  assign clip     = !cfg.weighted && (mag > {1'b0, cfg.threshold});
  assign accepted = clip ? ref_smp : in_chan.sample_in;

  assign ctrl.shift    = accept;
  assign ctrl.prime    = !primed_r;
  assign ctrl.advance  = advance;
  assign ctrl.weighted = cfg.weighted;

  for (genvar i = 0; i < TAPS; i++) begin : g_cell
    cwf_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .fill_smp (in_chan.sample_in),
      .nbr_smp  ((i == TAPS - 1) ? accepted : win[(i + 1) % TAPS]),
      .weight   (weight_for(cfg, i)),
      .smp_r    (win[i]),
      .prod_r   (prods[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      primed_r <= 1'b0;
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      clip1_r  <= 1'b0;
      clip2_r  <= 1'b0;
    end else begin
      if (accept) begin
        primed_r <= 1'b1;
      end
      if (advance) begin
        v1_r    <= accept;
        v2_r    <= v1_r;
        clip1_r <= clip && accept;
        clip2_r <= clip1_r;
      end
    end
  end

  cwf_out_stage u_out (
    .clk          (clk),
    .rst_n        (rst_n),
    .weighted     (cfg.weighted),
    .prod_valid   (v2_r),
    .prod_clipped (clip2_r),
    .prods        (prods),
    .advance      (advance),
    .out_chan     (out_chan)
  );

  a_primed_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && accept) |=> primed_r)
    else $error("primed flag not set after an accepted sample");

  a_first_fills_window: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && accept && !primed_r) |=> (win[0] == win[TAPS-1]))
    else $error("first sample did not fill the window");

  a_clip_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    clip1_r |-> v1_r)
    else $error("clip flag without an item in the window stage");

  a_out_from_stage2: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_chan.valid) |-> $past(v2_r))
    else $error("output request without a product stage item");

endmodule

### sv/cwf_cfg_regs.sv
`timescale 1ns / 1ps
module cwf_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cwf_pkg::ADDR_W-1:0]    paddr,
  input  logic [cwf_pkg::DATA_W-1:0]    pwdata,
  output logic [cwf_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  output cwf_pkg::cfg_t                 cfg
);
  import cwf_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_MODE:      cfg_nxt.weighted  = pwdata[0];
        REG_THRESHOLD: cfg_nxt.threshold = pwdata[SMP_W-1:0];
        REG_W_OLDEST:  cfg_nxt.w_oldest  = smp_t'(pwdata[SMP_W-1:0]);
        REG_W_SECOND:  cfg_nxt.w_second  = smp_t'(pwdata[SMP_W-1:0]);
        REG_W_THIRD:   cfg_nxt.w_third   = smp_t'(pwdata[SMP_W-1:0]);
        REG_W_NEWEST:  cfg_nxt.w_newest  = smp_t'(pwdata[SMP_W-1:0]);
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.weighted  <= MODE_RESET;
      cfg_r.threshold <= THRESH_RESET;
      cfg_r.w_oldest  <= WEIGHT_RESET;
      cfg_r.w_second  <= WEIGHT_RESET;
      cfg_r.w_third   <= WEIGHT_RESET;
      cfg_r.w_newest  <= WEIGHT_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (idx)
      REG_MODE:      prdata = {{(DATA_W-1){1'b0}}, cfg_r.weighted};
      REG_THRESHOLD: prdata = {{(DATA_W-SMP_W){1'b0}}, cfg_r.threshold};
      REG_W_OLDEST:  prdata = {{(DATA_W-SMP_W){cfg_r.w_oldest[SMP_W-1]}}, cfg_r.w_oldest};
      REG_W_SECOND:  prdata = {{(DATA_W-SMP_W){cfg_r.w_second[SMP_W-1]}}, cfg_r.w_second};
      REG_W_THIRD:   prdata = {{(DATA_W-SMP_W){cfg_r.w_third[SMP_W-1]}}, cfg_r.w_third};
      REG_W_NEWEST:  prdata = {{(DATA_W-SMP_W){cfg_r.w_newest[SMP_W-1]}}, cfg_r.w_newest};
      default:       prdata = '0;
    endcase
  end

endmodule

### sv/cwf_cell.sv
`timescale 1ns / 1ps
module cwf_cell (
  input  logic                 clk,
  input  cwf_pkg::cell_ctrl_t  ctrl,
  input  cwf_pkg::smp_t        fill_smp,
  input  cwf_pkg::smp_t        nbr_smp,
  input  cwf_pkg::smp_t        weight,
  output cwf_pkg::smp_t        smp_r,
  output cwf_pkg::prod_t       prod_r
);
  import cwf_pkg::*;

  smp_t  smp_nxt;
  prod_t prod_nxt;
  prod_t mult;

  assign mult     = PROD_W'(smp_r) * PROD_W'(weight);
  assign smp_nxt  = ctrl.prime ? fill_smp : nbr_smp;
  assign prod_nxt = ctrl.weighted ? mult : PROD_W'(smp_r);

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      smp_r <= smp_nxt;
    end
    if (ctrl.advance) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

### sv/cwf_out_stage.sv
`timescale 1ns / 1ps
module cwf_out_stage (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               weighted,
  input  logic                               prod_valid,
  input  logic                               prod_clipped,
  input  cwf_pkg::prod_t [cwf_pkg::TAPS-1:0] prods,
  output logic                               advance,
  cwf_out_if.source                          out_chan
);
  import cwf_pkg::*;

  localparam acc_t SAT_HI = acc_t'(32767);
  localparam acc_t SAT_LO = acc_t'(-32768);

  acc_t sum;
  acc_t scaled;
  smp_t sat;
  logic valid_r;
  smp_t filtered_r;
  logic clipped_r;

  always_comb begin
    sum = '0;
    for (int i = 0; i < TAPS; i++) begin
      sum = sum + ACC_W'(prods[i]);
    end
  end

  assign scaled = weighted ? (sum >>> FRAC_W) : (sum >>> TAPS_LOG2);

  always_comb begin
    if (scaled > SAT_HI) begin
      sat = smp_t'(SAT_HI);
    end else if (scaled < SAT_LO) begin
      sat = smp_t'(SAT_LO);
    end else begin
      sat = scaled[SMP_W-1:0];
    end
  end

  assign advance = !valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      filtered_r <= sat;
      clipped_r  <= prod_clipped;
    end
  end

  assign out_chan.valid        = valid_r;
  assign out_chan.filtered_out = filtered_r;
  assign out_chan.was_clipped  = clipped_r;

endmodule
